// ===== rtl/cbd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Chunked body deframer package
// Beat types shared by the parser and the top level.
// ----------------------------------------------------------------------------
package cbd_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       start_of_body;
    } cbd_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       end_of_body;
    } cbd_result_t;

endpackage

// ===== rtl/cbd_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Chunked body deframer channels
// Valid/ready channels for raw body bytes and for decoded result beats.
// ----------------------------------------------------------------------------
interface cbd_body_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       start_of_body;

    modport source (output valid, output data_byte, output start_of_body, input ready);
    modport sink   (input valid, input data_byte, input start_of_body, output ready);
endinterface

interface cbd_result_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       end_of_body;

    modport source (output valid, output out_byte, output end_of_body, input ready);
    modport sink   (input valid, input out_byte, input end_of_body, output ready);
endinterface

// ===== rtl/cbd_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Chunked body parser
// Holds the chunk framing state and decodes one registered byte per step.
// ----------------------------------------------------------------------------
module cbd_parser
    import cbd_pkg::*;
#(
    parameter int SIZE_BITS = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        step,
    input  cbd_item_t   item,
    output logic        res_valid,
    output cbd_result_t res
);

    typedef enum logic [1:0] {
        PH_SIZE,
        PH_DATA,
        PH_SKIP,
        PH_DONE
    } phase_t;

    localparam logic [7:0] CHAR_CR = 8'd13;
    localparam logic [7:0] CHAR_LF = 8'd10;

    phase_t                 phase_reg, phase_next, phase_cur;
    logic                   cr_reg, cr_next, cr_cur;
    logic [SIZE_BITS-1:0]   acc_reg, acc_next, acc_cur;
    logic [SIZE_BITS-1:0]   rem_reg, rem_next, rem_cur, rem_dec;
    logic [1:0]             skip_reg, skip_next, skip_cur, skip_dec;
    logic [3:0]             digit;
    logic [7:0]             c;

    assign c = item.data_byte;

    always_comb
    begin
        if (c inside {[8'h30:8'h39]})
            digit = c[3:0];
        else if (c inside {[8'h61:8'h66], [8'h41:8'h46]})
            digit = c[3:0] + 4'd9;
        else
            digit = 4'd0;
    end

    always_comb
    begin
        phase_cur = item.start_of_body ? PH_SIZE : phase_reg;
        cr_cur    = item.start_of_body ? 1'b0 : cr_reg;
        acc_cur   = item.start_of_body ? '0 : acc_reg;
        rem_cur   = item.start_of_body ? '0 : rem_reg;
        skip_cur  = item.start_of_body ? 2'd0 : skip_reg;
        rem_dec   = rem_cur - SIZE_BITS'(1);
        skip_dec  = skip_cur - 2'd1;

        phase_next = phase_cur;
        cr_next    = cr_cur;
        acc_next   = acc_cur;
        rem_next   = rem_cur;
        skip_next  = skip_cur;
        res_valid  = 1'b0;
        res        = '{out_byte: 8'd0, end_of_body: 1'b0};

        case (phase_cur)
            PH_SIZE:
            begin
                if (cr_cur && c == CHAR_LF)
                begin
                    cr_next = 1'b0;
                    if (acc_cur == '0)
                    begin
                        phase_next      = PH_DONE;
                        res_valid       = 1'b1;
                        res.end_of_body = 1'b1;
                    end
                    else
                    begin
                        rem_next   = acc_cur;
                        acc_next   = '0;
                        phase_next = PH_DATA;
                    end
                end
                else if (c == CHAR_CR)
                begin
                    cr_next  = 1'b1;
                    acc_next = cr_cur ? {acc_cur[SIZE_BITS-5:0], 4'd0} : acc_cur;
                end
                else
                begin
                    cr_next  = 1'b0;
                    acc_next = cr_cur ? {acc_cur[SIZE_BITS-9:0], 4'd0, digit}
                                      : {acc_cur[SIZE_BITS-5:0], digit};
                end
            end
            PH_DATA:
            begin
                res_valid    = 1'b1;
                res.out_byte = c;
                rem_next     = rem_dec;
                if (rem_dec == '0)
                begin
                    phase_next = PH_SKIP;
                    skip_next  = 2'd2;
                end
            end
            PH_SKIP:
            begin
                skip_next = skip_dec;
                if (skip_dec == 2'd0)
                begin
                    phase_next = PH_SIZE;
                    cr_next    = 1'b0;
                    acc_next   = '0;
                end
            end
            default:
            begin
                phase_next = PH_DONE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_SIZE;
            cr_reg    <= 1'b0;
            acc_reg   <= '0;
            rem_reg   <= '0;
            skip_reg  <= 2'd0;
        end
        else if (step)
        begin
            phase_reg <= phase_next;
            cr_reg    <= cr_next;
            acc_reg   <= acc_next;
            rem_reg   <= rem_next;
            skip_reg  <= skip_next;
        end
    end

endmodule

// ===== rtl/chunked_body_deframer_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Chunked body deframer core
// Decodes an HTTP chunked body byte stream into payload beats and an end mark.
// ----------------------------------------------------------------------------
// One body byte is taken per clock: the byte lands in an input register, the
// parser decodes it combinationally against the chunk state, and any payload
// byte or end-of-body beat lands in an output register. Throughput is one
// byte per cycle, limited only by back-pressure on the result channel. Size
// lines, the two bytes after each chunk and all bytes after the terminating
// zero-size chunk give no result beat. Raise start_of_body on the first byte
// of a new body.
// ----------------------------------------------------------------------------
module chunked_body_deframer_core
    import cbd_pkg::*;
#(
    parameter int SIZE_BITS = 32
)
(
    input  logic                clk,
    input  logic                rst_n,
    cbd_body_if.sink            body,
    cbd_result_if.source        result
);

    logic        in_valid_reg;
    cbd_item_t   item_reg;
    logic        out_valid_reg, out_valid_next;
    cbd_result_t out_reg;
    logic        advance;
    logic        res_valid;
    cbd_result_t res;

    assign advance    = in_valid_reg && (!out_valid_reg || result.ready);
    assign body.ready = !in_valid_reg || advance;

    cbd_parser #(
        .SIZE_BITS (SIZE_BITS)
    ) u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .item      (item_reg),
        .res_valid (res_valid),
        .res       (res)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = res_valid;
        else if (result.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (body.ready)
                in_valid_reg <= body.valid;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (body.valid && body.ready)
            item_reg <= '{data_byte: body.data_byte, start_of_body: body.start_of_body};
        if (advance && res_valid)
            out_reg <= res;
    end

    assign result.valid       = out_valid_reg;
    assign result.out_byte    = out_reg.out_byte;
    assign result.end_of_body = out_reg.end_of_body;

endmodule

// ===== dv/tb_chunked_body_deframer_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Chunked body deframer core testbench
// Drives chunked bodies and line noise into the body channel with random
// gaps, mirrors the decoder state in a scoreboard class, and checks every
// result beat in order against the predicted payload bytes and end marks.
// ----------------------------------------------------------------------------
module tb_chunked_body_deframer_core;
    import cbd_pkg::*;

    localparam int          SIZE_BITS     = 32;
    localparam logic [7:0]  CHAR_CR       = 8'h0D;
    localparam logic [7:0]  CHAR_LF       = 8'h0A;
    localparam int unsigned RANDOM_BEATS  = 1450;
    localparam int unsigned HOLD_AT       = 400;
    localparam int unsigned HOLD_CYCLES   = 300;
    localparam int unsigned QUIET_FROM    = 800;
    localparam int unsigned QUIET_TO      = 1000;
    localparam int unsigned DRAIN_CYCLES  = 10;
    localparam int unsigned CYCLE_LIMIT   = 400000;
    localparam int unsigned MAX_PRINTED   = 100;

    typedef enum logic [1:0] {
        SIZE_LINE = 2'd0,
        PAYLOAD   = 2'd1,
        TRAILER   = 2'd2,
        FINISHED  = 2'd3
    } parse_phase_t;

    class deframe_tracker;
        parse_phase_t         phase;
        bit                   cr_pending;
        logic [SIZE_BITS-1:0] size_acc;
        logic [SIZE_BITS-1:0] remaining;
        logic [1:0]           skip_left;
        cbd_result_t          expected_q[$];
        int unsigned          errors;

        function new();
            errors = 0;
            clear();
        endfunction

        function void clear();
            phase      = SIZE_LINE;
            cr_pending = 1'b0;
            size_acc   = '0;
            remaining  = '0;
            skip_left  = '0;
        endfunction

        function logic [3:0] hex_value(logic [7:0] c);
            if (c >= "0" && c <= "9")
                return 4'(c - "0");
            if (c >= "a" && c <= "f")
                return 4'(c - "a" + 8'd10);
            if (c >= "A" && c <= "F")
                return 4'(c - "A" + 8'd10);
            return 4'd0;
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction

        function void take_body_beat(logic [7:0] c, logic sob);
            cbd_result_t r;
            if (sob)
                clear();
            case (phase)
                SIZE_LINE:
                begin
                    if (cr_pending)
                    begin
                        cr_pending = 1'b0;
                        if (c == CHAR_LF)
                        begin
                            if (size_acc == '0)
                            begin
                                phase         = FINISHED;
                                r.out_byte    = 8'h00;
                                r.end_of_body = 1'b1;
                                expected_q    = {expected_q, r};
                            end
                            else
                            begin
                                remaining = size_acc;
                                size_acc  = '0;
                                phase     = PAYLOAD;
                            end
                            return;
                        end
                        size_acc = size_acc << 4;
                    end
                    if (c == CHAR_CR)
                        cr_pending = 1'b1;
                    else
                        size_acc = (size_acc << 4) | SIZE_BITS'(hex_value(c));
                end
                PAYLOAD:
                begin
                    r.out_byte    = c;
                    r.end_of_body = 1'b0;
                    expected_q    = {expected_q, r};
                    remaining = remaining - 1'b1;
                    if (remaining == '0)
                    begin
                        phase     = TRAILER;
                        skip_left = 2'd2;
                    end
                end
                TRAILER:
                begin
                    skip_left = skip_left - 1'b1;
                    if (skip_left == 2'd0)
                    begin
                        phase      = SIZE_LINE;
                        cr_pending = 1'b0;
                        size_acc   = '0;
                    end
                end
                default:
                begin
                end
            endcase
        endfunction

        task report(string msg);
            if (errors < MAX_PRINTED)
                $display("ERROR at %0t: %s", $realtime, msg);
            errors++;
        endtask

        task check_result_beat(logic [7:0] ob, logic eob);
            cbd_result_t want;
            if (expected_q.size() == 0)
            begin
                report($sformatf("unexpected beat out_byte=%02h end_of_body=%0b", ob, eob));
                return;
            end
            want = expected_q.pop_front();
            if (ob !== want.out_byte)
                report($sformatf("out_byte %02h, want %02h", ob, want.out_byte));
            if (eob !== want.end_of_body)
                report($sformatf("end_of_body %0b, want %0b", eob, want.end_of_body));
        endtask
    endclass

    logic clk;
    logic rst_n;
    int unsigned n_in;
    int unsigned cycles;
    deframe_tracker tracker = new();

    cbd_body_if   body();
    cbd_result_if result();

    chunked_body_deframer_core #(
        .SIZE_BITS (SIZE_BITS)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .body   (body),
        .result (result)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic bit quiet_stretch();
        return n_in >= QUIET_FROM && n_in < QUIET_TO;
    endfunction

    task automatic put_beat(input logic [7:0] b, input logic sob);
        while (!quiet_stretch() && $urandom_range(99) < 13)
        begin
            body.valid <= 1'b0;
            @(posedge clk);
        end
        body.valid         <= 1'b1;
        body.data_byte     <= b;
        body.start_of_body <= sob;
        do
            @(posedge clk);
        while (!body.ready);
        tracker.take_body_beat(b, sob);
        n_in++;
    endtask

    function automatic logic [7:0] hex_char(int unsigned d);
        if (d < 10)
            return 8'h30 + d[7:0];
        return ($urandom_range(1) ? "A" : "a") + d[7:0] - 8'd10;
    endfunction

    task automatic send_size_line(input int unsigned size, input logic sob);
        int unsigned pre;
        int unsigned k;
        int unsigned nib;
        logic [7:0]  ch;
        logic        s;
        s   = sob;
        pre = ($urandom_range(3) == 0) ? $urandom_range(2, 1) : 0;
        for (k = 0; k < pre; k++)
        begin
            case ($urandom_range(3))
                0: ch = "0";
                1: ch = ";";
                2: ch = " ";
                default: ch = CHAR_CR;
            endcase
            put_beat(ch, s);
            s = 1'b0;
        end
        nib = (size > 15) ? 2 : 1;
        for (k = nib; k > 0; k--)
        begin
            put_beat(hex_char((size >> (4 * (k - 1))) & 15), s);
            s = 1'b0;
        end
        put_beat(CHAR_CR, 1'b0);
        put_beat(CHAR_LF, 1'b0);
    endtask

    task automatic send_body();
        int unsigned n_chunks;
        int unsigned size;
        int unsigned c;
        int unsigned i;
        logic        first;
        first    = 1'b1;
        n_chunks = $urandom_range(4);
        for (c = 0; c < n_chunks; c++)
        begin
            size = ($urandom_range(9) == 0) ? $urandom_range(40, 1) : $urandom_range(8, 1);
            send_size_line(size, first);
            first = 1'b0;
            for (i = 0; i < size; i++)
                put_beat(8'($urandom_range(255)), 1'b0);
            if ($urandom_range(9) < 7)
            begin
                put_beat(CHAR_CR, 1'b0);
                put_beat(CHAR_LF, 1'b0);
            end
            else
            begin
                put_beat(8'($urandom_range(255)), 1'b0);
                put_beat(8'($urandom_range(255)), 1'b0);
            end
        end
        send_size_line(0, first);
        repeat ($urandom_range(3))
            put_beat(8'($urandom_range(255)), 1'b0);
    endtask

    task automatic send_noise();
        int unsigned len;
        int unsigned i;
        len = $urandom_range(24, 1);
        for (i = 0; i < len; i++)
            put_beat(8'($urandom_range(255)), (i == 0) || ($urandom_range(99) < 4));
    endtask

    initial
    begin : result_side
        int unsigned hold_left;
        bit          hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        result.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && result.valid && result.ready)
                tracker.check_result_beat(result.out_byte, result.end_of_body);
            if (!hold_done && n_in >= HOLD_AT)
            begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                result.ready <= 1'b0;
            end
            else
                result.ready <= quiet_stretch() || ($urandom_range(99) >= 13);
        end
    end

    initial
    begin : body_side
        int unsigned directed_beats;
        n_in   = 0;
        cycles = 0;
        rst_n               <= 1'b0;
        body.valid          <= 1'b0;
        body.data_byte      <= 8'h00;
        body.start_of_body  <= 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // lone CR ahead of a one-byte chunk, extreme payload and trailer bytes
        put_beat(CHAR_CR, 1'b1);
        put_beat("1", 1'b0);
        put_beat(CHAR_CR, 1'b0);
        put_beat(CHAR_LF, 1'b0);
        put_beat(8'hFF, 1'b0);
        put_beat(8'h00, 1'b0);
        put_beat(8'h80, 1'b0);
        // oversized size line: upper digits drop out, junk counts as zero
        put_beat("F", 1'b0);
        put_beat("a", 1'b0);
        put_beat(";", 1'b0);
        put_beat(" ", 1'b0);
        repeat (5) put_beat("0", 1'b0);
        put_beat("2", 1'b0);
        put_beat(CHAR_CR, 1'b0);
        put_beat(CHAR_LF, 1'b0);
        put_beat(8'h00, 1'b0);
        put_beat(8'h7F, 1'b0);
        put_beat(8'h55, 1'b0);
        put_beat(8'hAA, 1'b0);
        // terminating chunk, then a byte that must be dropped
        put_beat("0", 1'b0);
        put_beat(CHAR_CR, 1'b0);
        put_beat(CHAR_LF, 1'b0);
        put_beat(8'h41, 1'b0);

        directed_beats = n_in;
        while (n_in < directed_beats + RANDOM_BEATS)
        begin
            if ($urandom_range(99) < 15)
                send_noise();
            else
                send_body();
        end
        body.valid <= 1'b0;

        while (tracker.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (tracker.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
